@@ hw/rtl/cepi_pkg.sv @@
package cepi_pkg;

	localparam int unsigned DW    = 32;
	localparam int unsigned QBITS = 31;

	localparam logic [DW-1:0] T_ONE = 32'h7fff_ffff;
	localparam logic [DW-1:0] T_NEG = 32'h8000_0000;

	typedef enum logic [1:0] {
		TM_MAX,
		TM_DIV,
		TM_MIN
	} tmode_t;

	typedef struct packed {
		logic signed [DW-1:0] a_x;
		logic signed [DW-1:0] a_y;
		logic signed [DW-1:0] a_z;
		logic signed [DW-1:0] a_r;
		logic signed [DW-1:0] b_x;
		logic signed [DW-1:0] b_y;
		logic signed [DW-1:0] b_z;
		logic signed [DW-1:0] b_r;
	} in_t;

	typedef struct packed {
		logic signed [DW-1:0] out_x;
		logic signed [DW-1:0] out_y;
		logic signed [DW-1:0] out_z;
		logic signed [DW-1:0] out_r;
		logic                 out_r_valid;
	} out_t;

	// Work item handed from cell to cell through the divider chain.
	typedef struct packed {
		tmode_t               mode;
		logic                 neg;
		logic [DW-1:0]        rem;
		logic [DW-1:0]        dvs;
		logic [QBITS-1:0]     quo;
		logic                 rflag;
		logic signed [DW-1:0] a_x;
		logic signed [DW-1:0] a_z;
		logic signed [DW-1:0] a_r;
		logic signed [DW-1:0] d_x;
		logic signed [DW-1:0] d_z;
		logic signed [DW-1:0] d_r;
	} cell_t;

endpackage

@@ hw/rtl/cepi_prep.sv @@
module cepi_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            interp_color,
	input  logic            in_valid,
	output logic            in_ready,
	input  cepi_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output cepi_pkg::cell_t out_cell
);
	import cepi_pkg::*;

	logic            v_q;
	cell_t           c_q;
	cell_t           c_d;
	logic signed [DW-1:0] da;
	logic signed [DW-1:0] diff;
	logic signed [DW-1:0] ndiff;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_cell  = c_q;

	always_comb begin
		da    = in_data.a_y + in_data.a_z;
		diff  = da - (in_data.b_y + in_data.b_z);
		ndiff = -diff;
		c_d       = '0;
		if (!(da < diff)) begin
			c_d.mode = TM_MAX;
		end else if (ndiff < da) begin
			c_d.mode = TM_DIV;
		end else begin
			c_d.mode = TM_MIN;
		end
		c_d.neg   = da[DW-1];
		c_d.rem   = da[DW-1] ? DW'(-da) : da;
		c_d.dvs   = diff;
		c_d.quo   = '0;
		c_d.rflag = interp_color;
		c_d.a_x   = in_data.a_x;
		c_d.a_z   = in_data.a_z;
		c_d.a_r   = in_data.a_r;
		c_d.d_x   = in_data.b_x - in_data.a_x;
		c_d.d_z   = in_data.b_z - in_data.a_z;
		c_d.d_r   = in_data.b_r - in_data.a_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			c_q <= c_d;
		end
	end

endmodule

@@ hw/rtl/cepi_div_cell.sv @@
module cepi_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cepi_pkg::cell_t in_cell,
	output logic            out_valid,
	input  logic            out_ready,
	output cepi_pkg::cell_t out_cell
);
	import cepi_pkg::*;

	logic          v_q;
	cell_t         c_q;
	cell_t         c_d;
	logic [DW:0]   rem2;
	logic [DW:0]   sub;
	logic          qbit;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_cell  = c_q;

	// One restoring step: shift in a zero, subtract the divisor if it fits.
	always_comb begin
		rem2 = {in_cell.rem, 1'b0};
		sub  = rem2 - {1'b0, in_cell.dvs};
		qbit = !sub[DW];
		c_d      = in_cell;
		c_d.rem  = qbit ? sub[DW-1:0] : rem2[DW-1:0];
		c_d.quo  = {in_cell.quo[QBITS-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			c_q <= c_d;
		end
	end

endmodule

@@ hw/rtl/cepi_lerp.sv @@
module cepi_lerp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cepi_pkg::cell_t in_cell,
	output logic            out_valid,
	input  logic            out_ready,
	output cepi_pkg::out_t  out_data
);
	import cepi_pkg::*;

	logic                   v_s1, v_s2, v_s3;
	logic                   rdy_s1, rdy_s2, rdy_s3;
	logic signed [DW-1:0]   t_s1;
	logic signed [DW-1:0]   t_d;
	cell_t                  c_s1;
	logic signed [2*DW-1:0] p_x_s2, p_z_s2, p_r_s2;
	logic signed [DW-1:0]   a_x_s2, a_z_s2, a_r_s2;
	logic                   rflag_s2;
	out_t                   o_s3;
	out_t                   o_d;
	logic [DW-1:0]          qv;

	assign rdy_s3    = !v_s3 || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_s3;
	assign out_data  = o_s3;

	// Pick the factor and restore the quotient sign.
	always_comb begin
		qv = {1'b0, in_cell.quo};
		unique case (in_cell.mode)
			TM_MAX:  t_d = T_ONE;
			TM_DIV:  t_d = in_cell.neg ? DW'(-qv) : qv;
			TM_MIN:  t_d = T_NEG;
			default: t_d = T_ONE;
		endcase
	end

	always_comb begin
		o_d             = '0;
		o_d.out_x       = p_x_s2[2*DW-2:DW-1] + a_x_s2;
		o_d.out_z       = p_z_s2[2*DW-2:DW-1] + a_z_s2;
		o_d.out_y       = -o_d.out_z;
		o_d.out_r       = rflag_s2 ? (p_r_s2[2*DW-2:DW-1] + a_r_s2) : '0;
		o_d.out_r_valid = rflag_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			t_s1 <= t_d;
			c_s1 <= in_cell;
		end
		if (rdy_s2 && v_s1) begin
			p_x_s2   <= (2*DW)'($signed(c_s1.d_x)) * (2*DW)'(t_s1);
			p_z_s2   <= (2*DW)'($signed(c_s1.d_z)) * (2*DW)'(t_s1);
			p_r_s2   <= (2*DW)'($signed(c_s1.d_r)) * (2*DW)'(t_s1);
			a_x_s2   <= c_s1.a_x;
			a_z_s2   <= c_s1.a_z;
			a_r_s2   <= c_s1.a_r;
			rflag_s2 <= c_s1.rflag;
		end
		if (rdy_s3 && v_s2) begin
			o_s3 <= o_d;
		end
	end

endmodule

@@ hw/rtl/clip_edge_bottom_plane_interp_core.sv @@
// Channel | Signals                      | Transfer when
// in      | in_valid, in_ready, in_data  | in_valid && in_ready
// out     | out_valid, out_ready, out_data | out_valid && out_ready
// cfg     | cfg_we, cfg_wdata            | cfg_we (no wait)
//
// One edge per cycle sustained while out_ready is held high; the pipeline has
// one setup stage, 31 divider cells, factor select, multiply, add/output register.
// The quotient comes from a chain of 31 restoring-division cells, one bit each.
// Reset clears all valid flags and interp_color; payload registers are not reset.
// Each stage moves when its successor is empty or moving, so a stalled output
// still lets upstream bubbles fill.
module clip_edge_bottom_plane_interp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           in_valid,
	output logic           in_ready,
	input  cepi_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cepi_pkg::out_t out_data
);
	import cepi_pkg::*;

	logic  interp_color_q;
	cell_t chain_cell [0:QBITS];
	logic  chain_vld  [0:QBITS];
	logic  chain_rdy  [0:QBITS];

	// Hold the color enable; the user must write it only while the pipe is empty, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_color_q <= 1'b0;
		end else if (cfg_we) begin
			interp_color_q <= cfg_wdata;
		end
	end

	// Form da, diff, factor mode, |da| and the attribute deltas.
	cepi_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.interp_color (interp_color_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (chain_vld[0]),
		.out_ready    (chain_rdy[0]),
		.out_cell     (chain_cell[0])
	);

	// Divider chain: each cell produces one quotient bit, MSB first.
	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		cepi_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_vld[i]),
			.in_ready  (chain_rdy[i]),
			.in_cell   (chain_cell[i]),
			.out_valid (chain_vld[i+1]),
			.out_ready (chain_rdy[i+1]),
			.out_cell  (chain_cell[i+1])
		);
	end

	// Select the factor, multiply, shift and add.
	cepi_lerp u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_vld[QBITS]),
		.in_ready  (chain_rdy[QBITS]),
		.in_cell   (chain_cell[QBITS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ hw/rtl/cepi_chk.sv @@
module cepi_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input cepi_pkg::out_t out_data
);
	import cepi_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_y_on_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_y == DW'(0 - out_data.out_z))
		else $error("out_y is not the negated out_z");

	a_r_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.out_r_valid |-> out_data.out_r == '0)
		else $error("out_r nonzero while color is off");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result dropped or changed");

endmodule

bind clip_edge_bottom_plane_interp_core cepi_chk u_cepi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
